// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the mask convolution unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication or expression at every clock edge outside reset.
`define IMC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define IMC_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

// File: rtl/imc_pkg.sv
// Shared types and constants of the mask convolution unit.
package imc_pkg;

    localparam int MASK_MAX = 8;
    localparam int KW       = 3;    // bits of a mask row or column offset
    localparam int TAPW     = 6;    // bits of a coefficient index
    localparam int PIXW     = 16;
    localparam int SUMW     = 40;
    localparam int PRODW    = 33;
    localparam int ROWW     = 12;
    localparam int COLW     = 10;
    localparam int CFGW     = 13;

    localparam logic [1:0] REG_MASK_ROWS  = 2'd0;
    localparam logic [1:0] REG_MASK_COLS  = 2'd1;
    localparam logic [1:0] REG_IMAGE_ROWS = 2'd2;
    localparam logic [1:0] REG_IMAGE_COLS = 2'd3;

    typedef struct packed {
        logic            accept;
        logic            start;
        logic            issue;
        logic [TAPW-1:0] tap;
        logic [KW-1:0]   row_off;
        logic [KW-1:0]   col_off;
        logic            load_out;
    } cmd_t;

    typedef struct packed {
        logic       hit;
        logic       out_free;
        logic [3:0] nr;
        logic [3:0] nc;
    } sts_t;

endpackage

// File: rtl/imc_datapath.sv
// Datapath: configuration, pixel counters, line store, coefficient table, MAC and output.
module imc_datapath import imc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [CFGW-1:0]        cfg_data,
    input  logic                   kind,
    input  logic [5:0]             coef_index,
    input  logic signed [15:0]     coef_value,
    input  logic [PIXW-1:0]        pixel,
    input  logic                   frame_start,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [ROWW-1:0]        out_row,
    output logic [COLW-1:0]        out_col,
    output logic signed [SUMW-1:0] value,
    output logic                   frame_done
);

    logic [3:0]  mask_rows_reg, mask_cols_reg;
    logic [12:0] image_rows_reg;
    logic [10:0] image_cols_reg;
    logic [3:0]  nr, nc, hr, hc;
    logic [12:0] p;
    logic [10:0] q;

    logic [ROWW-1:0] row_reg;
    logic [COLW-1:0] col_reg;
    logic [12:0] rc0, rc1, rc2, r1, ctr_i;
    logic [10:0] cc0, cc1, c1, ctr_j;
    logic        hit;
    logic        done_now;

    logic [KW-1:0]   slot_reg;
    logic [COLW-1:0] cb_reg;
    logic [ROWW-1:0] i_reg;
    logic [COLW-1:0] j_reg;
    logic            done_reg;

    logic [PIXW-1:0]   line_mem [0:MASK_MAX*1024-1];
    logic signed [15:0] coef_mem [0:63];
    logic [PIXW-1:0]   px_rd_reg;
    logic signed [15:0] cf_rd_reg;
    logic              rd_vld_reg, prod_vld_reg;
    logic signed [PRODW-1:0] prod_reg;
    logic signed [SUMW-1:0]  acc_reg;

    logic                   out_valid_reg;
    logic [ROWW-1:0]        out_row_reg;
    logic [COLW-1:0]        out_col_reg;
    logic signed [SUMW-1:0] value_reg;
    logic                   frame_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_rows_reg  <= 4'd8;
            mask_cols_reg  <= 4'd8;
            image_rows_reg <= 13'd1024;
            image_cols_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MASK_ROWS:  mask_rows_reg  <= cfg_data[3:0];
                REG_MASK_COLS:  mask_cols_reg  <= cfg_data[3:0];
                REG_IMAGE_ROWS: image_rows_reg <= cfg_data;
                REG_IMAGE_COLS: image_cols_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Out-of-range settings are clamped to the legal range.
    always_comb
    begin
        nr = (mask_rows_reg == 4'd0) ? 4'd1 : ((mask_rows_reg > 4'd8) ? 4'd8 : mask_rows_reg);
        nc = (mask_cols_reg == 4'd0) ? 4'd1 : ((mask_cols_reg > 4'd8) ? 4'd8 : mask_cols_reg);
        p  = (image_rows_reg == 13'd0) ? 13'd1
           : ((image_rows_reg > 13'd4096) ? 13'd4096 : image_rows_reg);
        q  = (image_cols_reg == 11'd0) ? 11'd1
           : ((image_cols_reg > 11'd1024) ? 11'd1024 : image_cols_reg);
        hr = {1'b0, nr[3:1]};
        hc = {1'b0, nc[3:1]};
    end

    // Position of the arriving pixel and whether it completes a central window.
    always_comb
    begin
        cc0 = frame_start ? 11'd0 : {1'b0, col_reg};
        rc0 = frame_start ? 13'd0 : {1'b0, row_reg};
        rc1 = (cc0 >= q) ? rc0 + 13'd1 : rc0;
        cc1 = (cc0 >= q) ? 11'd0 : cc0;
        rc2 = (rc1 >= p) ? 13'd0 : rc1;
        r1  = rc2 + 13'd1;
        c1  = cc1 + 11'd1;
        ctr_i = r1 - {9'd0, nr} + {9'd0, hr};
        ctr_j = c1 - {7'd0, nc} + {7'd0, hc};
        hit = (r1 >= {9'd0, nr}) && (c1 >= {7'd0, nc})
            && (ctr_i + {9'd0, hr} < p) && (ctr_j + {7'd0, hc} < q);
        done_now = (ctr_i + {9'd0, hr} + 13'd1 == p) && (ctr_j + {7'd0, hc} + 11'd1 == q);
    end

    assign sts.hit      = kind & hit;
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign sts.nr       = nr;
    assign sts.nc       = nc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.accept && kind)
        begin
            if (c1 >= q)
            begin
                col_reg <= '0;
                row_reg <= (r1 >= p) ? '0 : r1[ROWW-1:0];
            end
            else
            begin
                col_reg <= c1[COLW-1:0];
                row_reg <= rc2[ROWW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            slot_reg <= KW'(r1 - {9'd0, nr});
            cb_reg   <= COLW'(c1 - {7'd0, nc});
            i_reg    <= ctr_i[ROWW-1:0];
            j_reg    <= ctr_j[COLW-1:0];
            done_reg <= done_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && kind)
            line_mem[{rc2[KW-1:0], cc1[COLW-1:0]}] <= pixel;
        if (cmd.issue)
            px_rd_reg <= line_mem[{KW'(slot_reg + cmd.row_off),
                                   COLW'(cb_reg + {{(COLW-KW){1'b0}}, cmd.col_off})}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && !kind)
            coef_mem[coef_index] <= coef_value;
        if (cmd.issue)
            cf_rd_reg <= coef_mem[cmd.tap];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, px_rd_reg}) * cf_rd_reg;
        if (cmd.start)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= acc_reg + SUMW'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_row_reg    <= i_reg;
            out_col_reg    <= j_reg;
            value_reg      <= acc_reg;
            frame_done_reg <= done_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign value      = value_reg;
    assign frame_done = frame_done_reg;

endmodule

// File: rtl/imc_ctrl.sv
// Controller: accepts beats and sequences the window taps through the MAC.
module imc_ctrl import imc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic kind,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [KW-1:0]   k_reg, k_next, l_reg, l_next;
    logic [TAPW-1:0] tap_reg, tap_next;
    logic            drain_reg, drain_next;
    logic            accept, last_col, last_tap;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign last_col = ({1'b0, l_reg} == sts.nc - 4'd1);
    assign last_tap = last_col && ({1'b0, k_reg} == sts.nr - 4'd1);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        l_next     = l_reg;
        tap_next   = tap_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                k_next   = '0;
                l_next   = '0;
                tap_next = '0;
                if (accept && kind && sts.hit)
                    state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                tap_next = tap_reg + TAPW'(1);
                if (last_col)
                begin
                    l_next = '0;
                    k_next = k_reg + KW'(1);
                end
                else
                    l_next = l_reg + KW'(1);
                if (last_tap)
                begin
                    state_next = S_DRAIN;
                    drain_next = 1'b1;
                end
            end
            S_DRAIN:
            begin
                // Lets the last product reach the accumulator.
                drain_next = 1'b0;
                if (!drain_reg)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            l_reg     <= '0;
            tap_reg   <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            l_reg     <= l_next;
            tap_reg   <= tap_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        cmd.accept   = accept;
        cmd.start    = accept && kind && sts.hit;
        cmd.issue    = (state_reg == S_ISSUE);
        cmd.tap      = tap_reg;
        cmd.row_off  = k_reg;
        cmd.col_off  = l_reg;
        cmd.load_out = (state_reg == S_EMIT) && sts.out_free;
    end

endmodule

// File: rtl/image_mask_convolution_unit.sv
// Top level of the mask convolution unit: controller plus datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  input    | in_valid / in_stall | kind, coef_index, coef_value, pixel,
//           |                     | frame_start
//  output   | out_valid/out_stall | out_row, out_col, value, frame_done
//  config   | cfg_we              | cfg_index, cfg_data
//
// A coefficient beat or a border pixel is taken without a stall.
// A central pixel stalls the input while one tap per cycle goes through
// the single line-store read port and the single multiplier, then the MAC drains.
// Reset clears the counters and the controller; the stores need no clearing.
// A result waits in the output register while the next beat is taken.
`include "assert_macros.svh"
module image_mask_convolution_unit import imc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [CFGW-1:0]        cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   kind,
    input  logic [5:0]             coef_index,
    input  logic signed [15:0]     coef_value,
    input  logic [PIXW-1:0]        pixel,
    input  logic                   frame_start,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [ROWW-1:0]        out_row,
    output logic [COLW-1:0]        out_col,
    output logic signed [SUMW-1:0] value,
    output logic                   frame_done
);

    cmd_t cmd;
    sts_t sts;

    imc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    imc_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .pixel       (pixel),
        .frame_start (frame_start),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_row     (out_row),
        .out_col     (out_col),
        .value       (value),
        .frame_done  (frame_done)
    );

    `IMC_ASSERT(a_load_free, cmd.load_out |-> (!out_valid || !out_stall), "result overwritten")
    `IMC_ASSERT(a_no_accept_busy, cmd.issue |-> in_stall, "beat taken during taps")
    `IMC_ASSERT_NEXT(a_start_issue, cmd.start, cmd.issue, "taps did not follow a start")
    `IMC_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid, "loaded result not shown")

endmodule
